@@ hw/rtl/desb_pkg.sv @@
package desb_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_GET        = 3'd4,
    MODE_SET        = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RDONE,
    ST_HOLD
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic write;
    logic rd_shift;
  } cell_cmd_t;

endpackage

@@ hw/rtl/desb_cell.sv @@
module desb_cell import desb_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 8,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IW-1:0]         wr_slot,
  input  logic [IW-1:0]         rd_slot,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] below,
  input  logic [DATA_WIDTH-1:0] above,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_out
);

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      data <= below;
    end else if (cmd.shift_down) begin
      data <= above;
    end else if (cmd.write && (wr_slot == IW'(POS))) begin
      data <= wr_data;
    end
  end

  // read chain: the selected cell injects its word, the others pass it toward cell 0
  always_ff @(posedge clk) begin
    if (cmd.rd_shift) begin
      rd_out <= (rd_slot == IW'(POS)) ? data : rd_in;
    end
  end

endmodule

@@ hw/rtl/desb_ctrl.sv @@
module desb_ctrl import desb_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [2:0]            mode,
  input  logic [7:0]            index,
  input  logic signed [31:0]    value,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic signed [31:0]    read_value,
  output logic [1:0]            status,
  output logic [8:0]            fill_count,
  output cell_cmd_t             cmd,
  output logic [IW-1:0]         wr_slot,
  output logic [IW-1:0]         rd_slot,
  output logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [IW-1:0]          wait_cnt, wait_cnt_next;
  logic [IW-1:0]          rd_slot_next;
  status_t                pend, pend_next;
  status_t                res;
  status_t                out_status_next;
  logic signed [31:0]     out_value_next;
  logic                   out_load;
  logic                   acc;
  logic                   out_free;
  logic                   is_full;
  logic                   is_empty;
  logic                   set_ok;
  logic                   get_ok;
  logic [XW-1:0]          idx_x;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [31:0]     rd_ext;

  assign idx_x    = XW'(index);
  assign set_ok   = idx_x < XW'(DEPTH);
  assign get_ok   = idx_x < XW'(count);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign acc      = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign wr_data  = DATA_WIDTH'(value);
  assign rd_s     = rd_data;
  assign rd_ext   = 32'(rd_s);
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    wait_cnt_next   = wait_cnt;
    rd_slot_next    = rd_slot;
    pend_next       = pend;
    cmd             = '0;
    wr_slot         = count[IW-1:0];
    res             = STATUS_OK;
    out_load        = 1'b0;
    out_value_next  = '0;
    out_status_next = STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (mode_t'(mode))
            MODE_PUSH_BACK: begin
              if (is_full) begin
                res = STATUS_FULL;
              end else begin
                cmd.write  = 1'b1;
                count_next = count + CW'(1);
              end
            end
            MODE_PUSH_FRONT: begin
              if (is_full) begin
                res = STATUS_FULL;
              end else begin
                cmd.shift_up = 1'b1;
                count_next   = count + CW'(1);
              end
            end
            MODE_POP_BACK: begin
              if (is_empty) begin
                res = STATUS_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (is_empty) begin
                res = STATUS_EMPTY;
              end else begin
                cmd.shift_down = 1'b1;
                count_next     = count - CW'(1);
              end
            end
            MODE_GET: begin
              if (!get_ok) begin
                res = STATUS_RANGE;
              end
            end
            MODE_SET: begin
              if (!set_ok) begin
                res = STATUS_RANGE;
              end else begin
                cmd.write = 1'b1;
                wr_slot   = idx_x[IW-1:0];
              end
            end
            default: ;
          endcase
          if ((mode == MODE_GET) && get_ok) begin
            state_next    = ST_READ;
            wait_cnt_next = idx_x[IW-1:0];
            rd_slot_next  = idx_x[IW-1:0];
          end else if (out_free) begin
            out_load        = 1'b1;
            out_status_next = res;
          end else begin
            pend_next  = res;
            state_next = ST_HOLD;
          end
        end
      end
      ST_READ: begin
        // one hop per cycle from the selected cell down to cell 0
        cmd.rd_shift = 1'b1;
        if (wait_cnt == '0) begin
          state_next = ST_RDONE;
        end else begin
          wait_cnt_next = wait_cnt - IW'(1);
        end
      end
      ST_RDONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_value_next = rd_ext;
          state_next     = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = pend;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wait_cnt <= wait_cnt_next;
    rd_slot  <= rd_slot_next;
    pend     <= pend_next;
    if (out_load) begin
      read_value <= out_value_next;
      status     <= out_status_next;
      fill_count <= 9'(count_next);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above capacity");

  a_get_read: assert property (@(posedge clk) disable iff (rst)
    acc && (mode == MODE_GET) && get_ok |=> state == ST_READ)
    else $error("in-range get did not start the read chain");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(count))
    else $error("count moved without a transaction");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    acc && ((mode == MODE_PUSH_BACK) || (mode == MODE_PUSH_FRONT)) && !is_full
    |=> count == $past(count) + CW'(1))
    else $error("successful push did not grow the count");

endmodule

@@ hw/rtl/double_ended_shift_buffer.sv @@
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  mode, index, value
// response  out        rsp_valid / rsp_ready  read_value, status, fill_count
//
// push, pop, set and failed operations: one transaction per cycle while the response
// is not stalled; the result is registered at acceptance, or via the hold state.
// get: the word moves one hop per cell along the read chain to cell 0 in the read
// state; no new request is taken until its response is registered.
// reset clears the count and the handshake state only; slot contents are not cleared.
// a stalled response lets one more request in, which waits in the hold state (a get,
// in read-done); further requests wait until the stalled response is taken.
module double_ended_shift_buffer import desb_pkg::*; #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         mode,
  input  logic [7:0]         index,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [8:0]         fill_count
);

  localparam int IW = $clog2(DEPTH);

  cell_cmd_t             cmd;
  logic [IW-1:0]         wr_slot;
  logic [IW-1:0]         rd_slot;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] slot_data [DEPTH];
  logic [DATA_WIDTH-1:0] rd_chain  [DEPTH];

  desb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .index      (index),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count),
    .cmd        (cmd),
    .wr_slot    (wr_slot),
    .rd_slot    (rd_slot),
    .wr_data    (wr_data),
    .rd_data    (rd_chain[0])
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] below;
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] rd_in;

    // cell 0 takes the pushed word on a front push
    if (g == 0) begin : g_first
      assign below = wr_data;
    end else begin : g_mid_lo
      assign below = slot_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above = '0;
      assign rd_in = '0;
    end else begin : g_mid_hi
      assign above = slot_data[g+1];
      assign rd_in = rd_chain[g+1];
    end

    desb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .POS        (g)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .wr_slot (wr_slot),
      .rd_slot (rd_slot),
      .wr_data (wr_data),
      .below   (below),
      .above   (above),
      .rd_in   (rd_in),
      .data    (slot_data[g]),
      .rd_out  (rd_chain[g])
    );
  end

endmodule

@@ tb/sv/double_ended_shift_buffer_tb.sv @@
`timescale 1ns / 100ps

module double_ended_shift_buffer_tb;
  import desb_pkg::*;

  localparam int DEPTH       = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = DEPTH + 40;

  // mode codes outside the package enum; the block ignores them
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [8:0]         fill_count;
  } buffer_result_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [2:0]         mode;
  logic [7:0]         index;
  logic signed [31:0] value;
  logic               rsp_valid;
  logic               rsp_ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [8:0]         fill_count;

  // shadow copy of the buffer contents
  logic signed [31:0] shadow_slots [DEPTH];
  int                 shadow_count;

  buffer_result_t     pending_results [$];
  bit                 idling_enabled;
  int                 fail_count;
  int                 items_sent;
  int                 results_checked;
  int                 peak_fill;
  int                 status_seen [4];
  int                 cycle_count;

  double_ended_shift_buffer #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .index      (index),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("double_ended_shift_buffer test failed");
    $finish;
  end

  function automatic buffer_result_t apply_buffer_op(input logic [2:0] op,
                                                     input logic [7:0] idx,
                                                     input logic signed [31:0] word);
    buffer_result_t r;
    r.read_value = '0;
    r.status     = STATUS_OK;
    case (op)
      MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_slots[shadow_count] = word;
          shadow_count++;
        end
      end
      MODE_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[0] = word;
          shadow_count++;
        end
      end
      MODE_POP_BACK: begin
        if (shadow_count == 0) r.status = STATUS_EMPTY;
        else shadow_count--;
      end
      MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
          shadow_count--;
        end
      end
      MODE_GET: begin
        if (idx >= shadow_count) r.status = STATUS_RANGE;
        else r.read_value = shadow_slots[idx];
      end
      MODE_SET: begin
        if (idx >= DEPTH) r.status = STATUS_RANGE;
        else shadow_slots[idx] = word;
      end
      default: ;
    endcase
    r.fill_count = 9'(shadow_count);
    return r;
  endfunction

  function automatic logic signed [31:0] random_word();
    logic signed [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'sh7fff_ffff;
      1: w = 32'sh8000_0000;
      2: w = '0;
      3: w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [7:0] idx,
                         input logic signed [31:0] word);
    buffer_result_t r;
    if (idling_enabled && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    index     <= idx;
    value     <= word;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    r = apply_buffer_op(op, idx, word);
    pending_results.push_back(r);
    items_sent++;
    status_seen[r.status]++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // response sink with random backpressure bursts
  initial begin : rsp_sink
    int stall_left;
    stall_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (idling_enabled && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    buffer_result_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no transaction outstanding: read_value %0d status %0d fill %0d",
               read_value, status, fill_count);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (read_value !== exp_r.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d", exp_r.read_value, read_value);
          fail_count++;
        end
        if (status !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
          fail_count++;
        end
        if (fill_count !== exp_r.fill_count) begin
          $error("fill_count mismatch: expected %0d, actual %0d", exp_r.fill_count,
                 fill_count);
          fail_count++;
        end
      end
    end
  end

  task automatic test_edge_cases();
    send_op(MODE_POP_BACK, 8'd0, 32'sd0);
    send_op(MODE_POP_FRONT, 8'd0, 32'sd0);
    send_op(MODE_GET, 8'd0, 32'sd0);
    send_op(MODE_RSVD6, 8'd255, '1);
    send_op(MODE_PUSH_BACK, 8'd0, 32'sh7fff_ffff);
    send_op(MODE_PUSH_FRONT, 8'd255, 32'sh8000_0000);
    send_op(MODE_PUSH_BACK, 8'd0, 32'sd0);
    send_op(MODE_PUSH_FRONT, 8'd0, '1);
    send_op(MODE_GET, 8'd0, 32'sd0);
    send_op(MODE_GET, 8'd3, 32'sd0);
    send_op(MODE_GET, 8'd4, 32'sd0);
    send_op(MODE_GET, 8'd255, '1);
    // set past the fill count writes the slot but leaves the count alone
    send_op(MODE_SET, 8'd200, 32'sd12345);
    send_op(MODE_SET, 8'd1, 32'sh5a5a_5a5a);
    send_op(MODE_GET, 8'd1, 32'sd0);
    send_op(MODE_RSVD7, 8'd170, 32'sh5555_5555);
    send_op(MODE_POP_FRONT, 8'd85, 32'shaaaa_aaaa);
    send_op(MODE_GET, 8'd0, 32'sd0);
    send_op(MODE_POP_BACK, 8'd0, 32'sd0);
    send_op(MODE_GET, 8'd1, 32'sd0);
    send_op(MODE_PUSH_BACK, 8'd0, 32'sh0bad_cafe);
    send_op(MODE_GET, 8'd2, 32'sd0);
  endtask

  // fill to capacity, poke the full boundary, then drain back to half
  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH) begin
      send_op($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 8'($urandom),
              random_word());
      if (shadow_count % 40 == 0)
        send_op(MODE_GET, 8'($urandom_range(0, shadow_count - 1)), '0);
    end
    send_op(MODE_PUSH_BACK, 8'd0, random_word());
    send_op(MODE_PUSH_FRONT, 8'd0, random_word());
    send_op(MODE_RSVD6, 8'd0, random_word());
    send_op(MODE_GET, 8'd255, '0);
    send_op(MODE_GET, 8'd0, '0);
    send_op(MODE_SET, 8'd255, 32'sh8000_0000);
    send_op(MODE_GET, 8'd255, '0);
    send_op(MODE_POP_FRONT, 8'd0, '0);
    send_op(MODE_PUSH_FRONT, 8'd0, 32'sh7fff_ffff);
    send_op(MODE_POP_BACK, 8'd0, '0);
    send_op(MODE_PUSH_BACK, 8'd0, '1);
    send_op(MODE_GET, 8'd255, '0);
    while (shadow_count > DEPTH / 2) begin
      send_op($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK, 8'($urandom),
              random_word());
      if (shadow_count % 50 == 1) send_op(MODE_GET, 8'(shadow_count - 1), '0);
    end
  endtask

  // push_pct biases pushes against pops so the fill level wanders
  task automatic send_random_op(input int push_pct);
    int                 roll;
    logic [2:0]         op;
    logic [7:0]         idx;
    logic signed [31:0] word;
    roll = $urandom_range(0, 99);
    word = random_word();
    idx  = 8'($urandom);
    if (roll < 60) begin
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    end else if (roll < 95) begin
      op = ($urandom_range(0, 2) == 0) ? MODE_SET : MODE_GET;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        idx = 8'($urandom_range(0, shadow_count - 1));
    end else begin
      op = $urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7;
    end
    send_op(op, idx, word);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 30; n++) send_random_op((phase % 2 == 0) ? 85 : 25);
    end
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 40; n++) send_random_op(50);
  endtask

  initial begin
    rst            <= 1'b1;
    req_valid      <= 1'b0;
    mode           <= '0;
    index          <= '0;
    value          <= '0;
    idling_enabled  = 1'b1;
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    peak_fill       = 0;
    shadow_count    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_fill_and_drain();
    test_random_mix();
    idling_enabled = 1'b0;
    test_back_to_back();

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transactions: %0d empty pops, %0d full pushes, %0d bad indexes",
             items_sent, status_seen[STATUS_EMPTY], status_seen[STATUS_FULL],
             status_seen[STATUS_RANGE]);
    $display("checked %0d responses, peak fill %0d of %0d", results_checked, peak_fill, DEPTH);
    if (fail_count == 0) begin
      $display("double_ended_shift_buffer test passed");
    end else begin
      $display("double_ended_shift_buffer test failed");
    end
    $finish;
  end

endmodule
